### hw/rtl/aoc_pkg.sv
package aoc_pkg;

   // colour channels handled in parallel: red, green, blue
   localparam int unsigned CHANNELS   = 3;
   localparam int unsigned CH_W       = 8;
   // s = fa*255 + ba*(255-fa) peaks at 65025
   localparam int unsigned SUM_W      = 16;
   // numerator peaks at 255*65025, below 2**24
   localparam int unsigned NUM_W      = 24;
   // quotient never exceeds 255, so one restoring step per bit
   localparam int unsigned QUO_W      = 8;
   localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

   typedef struct packed {
      logic [CHANNELS-1:0][CH_W-1:0] fg;
      logic [CH_W-1:0]               fa;
      logic [CHANNELS-1:0][CH_W-1:0] bg;
      logic [CH_W-1:0]               ba;
      logic                          last;
   } aoc_pix_type;

   typedef struct packed {
      logic [CHANNELS-1:0][NUM_W-1:0] rem;
      logic [CHANNELS-1:0][QUO_W-1:0] quo;
      logic [SUM_W-1:0]               wsum;
      logic [CH_W-1:0]                alpha;
      logic                           last;
   } aoc_div_type;

endpackage

### hw/rtl/aoc_front.sv
module aoc_front import aoc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  aoc_pix_type in_pix,
   output logic        out_valid,
   output aoc_div_type out_data
);

   // stage 1: weights
   logic                          s1_valid_ff;
   logic [SUM_W-1:0]              s1_fw_ff, s1_fw_in;
   logic [SUM_W-1:0]              s1_bw_ff, s1_bw_in;
   logic [CHANNELS-1:0][CH_W-1:0] s1_fg_ff, s1_bg_ff;
   logic                          s1_last_ff;
   logic [CH_W-1:0]               inv_fa;

   // stage 2: per-channel products
   logic                           s2_valid_ff;
   logic [CHANNELS-1:0][NUM_W-1:0] s2_pf_ff, s2_pf_in;
   logic [CHANNELS-1:0][NUM_W-1:0] s2_pb_ff, s2_pb_in;
   logic [SUM_W-1:0]               s2_wsum_ff, s2_wsum_in;
   logic                           s2_last_ff;

   // stage 3: numerators and alpha
   logic                           s3_valid_ff;
   aoc_div_type                    s3_data_ff, s3_data_in;
   logic [SUM_W:0]                 alpha_acc;

   assign inv_fa   = FULL_SCALE - in_pix.fa;
   // fa*255 as a shift and subtract
   assign s1_fw_in = {in_pix.fa, 8'd0} - SUM_W'(in_pix.fa);
   assign s1_bw_in = SUM_W'(in_pix.ba * inv_fa);

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         s2_pf_in[c] = NUM_W'(s1_fg_ff[c] * s1_fw_ff);
         s2_pb_in[c] = NUM_W'(s1_bg_ff[c] * s1_bw_ff);
      end
   end
   assign s2_wsum_in = s1_fw_ff + s1_bw_ff;

   // floor(s/255) = (s + 1 + (s >> 8)) >> 8 over the range of s
   assign alpha_acc = (SUM_W+1)'(s2_wsum_ff) + (SUM_W+1)'(1)
                      + (SUM_W+1)'(s2_wsum_ff >> 8);

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         s3_data_in.rem[c] = s2_pf_ff[c] + s2_pb_ff[c];
         s3_data_in.quo[c] = '0;
      end
      s3_data_in.wsum  = s2_wsum_ff;
      s3_data_in.alpha = alpha_acc[15:8];
      s3_data_in.last  = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_fw_ff   <= s1_fw_in;
         s1_bw_ff   <= s1_bw_in;
         s1_fg_ff   <= in_pix.fg;
         s1_bg_ff   <= in_pix.bg;
         s1_last_ff <= in_pix.last;
         s2_pf_ff   <= s2_pf_in;
         s2_pb_ff   <= s2_pb_in;
         s2_wsum_ff <= s2_wsum_in;
         s2_last_ff <= s1_last_ff;
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

### hw/rtl/aoc_div_stage.sv
module aoc_div_stage import aoc_pkg::*; #(
   parameter int unsigned SHIFT = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  aoc_div_type in_data,
   output logic        out_valid,
   output aoc_div_type out_data
);

   logic        valid_ff;
   aoc_div_type data_ff, data_in;
   logic [NUM_W-1:0] divisor;

   // divisor aligned to this quotient bit
   assign divisor = NUM_W'(in_data.wsum) << SHIFT;

   always_comb begin
      data_in = in_data;
      for (int c = 0; c < CHANNELS; c++) begin
         if (in_data.rem[c] >= divisor) begin
            data_in.rem[c]        = in_data.rem[c] - divisor;
            data_in.quo[c][SHIFT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hw/rtl/alpha_over_composite_core.sv
// porter-duff over compositing of one straight-alpha rgba8 pixel pair
//
// request channel: req_valid / req_stall carry one foreground and one
// background pixel plus the last pixel mark per transaction
// response channel: rsp_valid / rsp_stall carry the composited pixel,
// colours and alpha floored to eight bits, last mark copied through
//
// from request to response a transaction passes three front stages
// (weights, products, numerator sum with alpha) then eight restoring
// division stages, one quotient bit each, for all three colours at once
// throughput is one transaction per cycle, set by the pipeline register
// stages, unless a response stalls; all advance together on one enable
//
// a stalled response freezes the whole pipeline and raises req_stall in
// the same cycle, so no transaction is lost or repeated; while the
// response register is empty req_stall stays low
// reset is synchronous and clears only the valid bits, after which the
// pipeline is empty; when both alphas are zero the colours come out zero
module alpha_over_composite_core import aoc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_fg_red,
   input  logic [7:0] req_fg_green,
   input  logic [7:0] req_fg_blue,
   input  logic [7:0] req_fg_alpha,
   input  logic [7:0] req_bg_red,
   input  logic [7:0] req_bg_green,
   input  logic [7:0] req_bg_blue,
   input  logic [7:0] req_bg_alpha,
   input  logic       req_last_pixel,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic [7:0] rsp_out_alpha,
   output logic       rsp_out_last
);

   // pipeline moves only when the response register can be emptied
   logic        en;
   aoc_pix_type pix;

   // index 0 is the front end output, index QUO_W the final stage
   logic        div_valid [QUO_W+1];
   aoc_div_type div_data  [QUO_W+1];
   aoc_div_type res;
   logic        sum_zero;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // gather the request fields, red in lane 0
   assign pix.fg[0] = req_fg_red;
   assign pix.fg[1] = req_fg_green;
   assign pix.fg[2] = req_fg_blue;
   assign pix.fa    = req_fg_alpha;
   assign pix.bg[0] = req_bg_red;
   assign pix.bg[1] = req_bg_green;
   assign pix.bg[2] = req_bg_blue;
   assign pix.ba    = req_bg_alpha;
   assign pix.last  = req_last_pixel;

   aoc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_pix    (pix),
      .out_valid (div_valid[0]),
      .out_data  (div_data[0])
   );

   // quotient bits from the most significant down
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      aoc_div_stage #(
         .SHIFT (QUO_W - 1 - k)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[k]),
         .in_data   (div_data[k]),
         .out_valid (div_valid[k+1]),
         .out_data  (div_data[k+1])
      );
   end

   // last division register doubles as the response register
   assign res       = div_data[QUO_W];
   assign rsp_valid = div_valid[QUO_W];

   // zero total coverage: every restoring step passes, so force black
   assign sum_zero      = (res.wsum == '0);
   assign rsp_out_red   = sum_zero ? '0 : res.quo[0];
   assign rsp_out_green = sum_zero ? '0 : res.quo[1];
   assign rsp_out_blue  = sum_zero ? '0 : res.quo[2];
   assign rsp_out_alpha = res.alpha;
   assign rsp_out_last  = res.last;

endmodule

### hw/rtl/aoc_checker.sv
module aoc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_fg_red,
   input logic [7:0] req_fg_green,
   input logic [7:0] req_fg_blue,
   input logic [7:0] req_fg_alpha,
   input logic [7:0] req_bg_red,
   input logic [7:0] req_bg_green,
   input logic [7:0] req_bg_blue,
   input logic [7:0] req_bg_alpha,
   input logic       req_last_pixel,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_green,
   input logic [7:0] rsp_out_blue,
   input logic [7:0] rsp_out_alpha,
   input logic       rsp_out_last
);

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // input is only held off by a blocked response
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while response register is empty");

   // a blocked response keeps its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_red)
         && $stable(rsp_out_green) && $stable(rsp_out_blue)
         && $stable(rsp_out_alpha) && $stable(rsp_out_last))
      else $error("stalled response changed");

   // zero alpha only arises from zero total coverage, which gives black
   a_zero_cov: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_alpha == 8'd0 |-> rsp_out_red == 8'd0
         && rsp_out_green == 8'd0 && rsp_out_blue == 8'd0)
      else $error("non-black colour with zero coverage");

endmodule

bind alpha_over_composite_core aoc_checker u_aoc_checker (.*);
